[hw/rtl/shand_pkg.sv]
// Package with SHA-256 constants, types and round functions for the nonce check.
`timescale 1ns / 1ps
package shand_pkg;

    localparam int MSG_BYTES_DEF = 32;
    localparam int MSG_BYTES_MIN = 8;
    localparam int CFG_W = 64;
    localparam int CFG_IDX_W = 3;
    localparam int NONCE_W = 64;
    localparam int ROUNDS = 64;
    localparam int DIGEST_NIB = 32;

    localparam logic [CFG_IDX_W-1:0] REG_MSG0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MSG1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MSG2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MSG3 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LEN  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ZNIB = 3'd5;

    typedef logic [31:0] t_word;
    typedef t_word t_state [8];
    typedef t_word t_sched [16];

    localparam t_word ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam t_word INIT_H [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    function automatic t_word rotr(input t_word x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    function automatic t_word ssig0(input t_word x);
        ssig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic t_word ssig1(input t_word x);
        ssig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    function automatic t_word bsig0(input t_word x);
        bsig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic t_word bsig1(input t_word x);
        bsig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

endpackage

[hw/rtl/shand_round.sv]
// One SHA-256 round stage with its rolling message schedule window.
`timescale 1ns / 1ps
module shand_round
    import shand_pkg::*;
#(
    parameter int RoundIdx = 0
) (
    input  logic    i_clk,
    input  logic    i_en,
    input  t_state  i_v,
    input  t_sched  i_w,
    output t_state  o_v,
    output t_sched  o_w
);

    t_word  t1;
    t_word  t2;
    t_state n_v;
    t_sched n_w;
    t_state r_v;
    t_sched r_w;

    always_comb begin
        t1 = i_v[7] + bsig1(i_v[4]) + ((i_v[4] & i_v[5]) ^ (~i_v[4] & i_v[6]))
             + ROUND_K[RoundIdx] + i_w[0];
        t2 = bsig0(i_v[0]) + ((i_v[0] & i_v[1]) ^ (i_v[0] & i_v[2]) ^ (i_v[1] & i_v[2]));
        n_v[0] = t1 + t2;
        n_v[1] = i_v[0];
        n_v[2] = i_v[1];
        n_v[3] = i_v[2];
        n_v[4] = i_v[3] + t1;
        n_v[5] = i_v[4];
        n_v[6] = i_v[5];
        n_v[7] = i_v[6];
        // The window slides by one; the new tail is w[t+16].
        for (int j = 0; j < 15; j++) begin
            n_w[j] = i_w[j+1];
        end
        n_w[15] = i_w[0] + ssig0(i_w[1]) + i_w[9] + ssig1(i_w[14]);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_v <= n_v;
            r_w <= n_w;
        end
    end

    assign o_v = r_v;
    assign o_w = r_w;

endmodule

[hw/rtl/sha256_nonce_difficulty_check.sv]
// Top level of the SHA-256 nonce difficulty check pipeline.
// Usage: the sender offers one 64-bit nonce per request on i_valid/i_nonce; it is
// taken at a rising edge with i_valid high and o_stall low. Each nonce is added
// bytewise to message bytes 0..7, the configured message is padded to one block
// and hashed. The result request (o_valid, o_hit, digest words, tried nonce) is
// taken at an edge with o_valid high and i_stall low.
// There are 66 register stages: one block-build stage, 64 unrolled round stages
// and one stage for the final add and difficulty compare. A nonce moves through
// them in that order and leaves at o_valid, the valid bit of the last stage.
// One nonce per cycle while the output is not stalled; each round stage holds one item.
// Reset (synchronous, active low) clears all valid bits and sets the message to
// zero, the length to 32 bytes and the required zero nibbles to 2.
// When the receiver stalls while the output holds a result, the whole pipeline
// freezes and o_stall goes high; empty slots inside the pipeline are not closed
// up. A stall with no result at the output does not stop the pipeline.
// Configuration writes are taken at any edge with i_cfg_we high and must only
// be made while the pipeline is empty.
`timescale 1ns / 1ps
module sha256_nonce_difficulty_check
    import shand_pkg::*;
#(
    parameter int MAX_MESSAGE_BYTES = MSG_BYTES_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [NONCE_W-1:0]   i_nonce,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic                 o_hit,
    output logic [63:0]          o_digest_word_0,
    output logic [63:0]          o_digest_word_1,
    output logic [63:0]          o_digest_word_2,
    output logic [63:0]          o_digest_word_3,
    output logic [NONCE_W-1:0]   o_tried_nonce,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    localparam int NST = ROUNDS + 2;

    logic [63:0] r_msg [4];
    logic [5:0]  r_len;
    logic [5:0]  r_znib;

    // Global pipeline enable: advance unless the output holds a result that is stalled.
    logic adv;
    assign adv = !(o_valid && i_stall);
    assign o_stall = !adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_msg[0] <= '0;
            r_msg[1] <= '0;
            r_msg[2] <= '0;
            r_msg[3] <= '0;
            r_len    <= 6'd32;
            r_znib   <= 6'd2;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_MSG0: r_msg[0] <= i_cfg_data;
                REG_MSG1: r_msg[1] <= i_cfg_data;
                REG_MSG2: r_msg[2] <= i_cfg_data;
                REG_MSG3: r_msg[3] <= i_cfg_data;
                REG_LEN:  r_len    <= i_cfg_data[5:0];
                REG_ZNIB: r_znib   <= i_cfg_data[5:0];
                default: ;
            endcase
        end
    end

    // Block build: clamp length, add nonce, place padding and bit length.
    logic [5:0] eff_len;
    logic [7:0] blk [64];
    t_sched     n_blkw;
    always_comb begin
        logic [7:0] b;
        eff_len = r_len;
        if (r_len < 6'(MSG_BYTES_MIN)) eff_len = 6'(MSG_BYTES_MIN);
        if (r_len > 6'(MAX_MESSAGE_BYTES)) eff_len = 6'(MAX_MESSAGE_BYTES);
        for (int i = 0; i < 64; i++) begin
            b = 8'h00;
            if (i < 32) b = r_msg[i/8][8*(i%8) +: 8];
            if (i < 8) b = b + i_nonce[8*i +: 8];
            if (i < 62) begin
                if (6'(i) < eff_len && i < MAX_MESSAGE_BYTES) blk[i] = b;
                else if (6'(i) == eff_len) blk[i] = 8'h80;
                else blk[i] = 8'h00;
            end else begin
                blk[i] = 8'h00;
            end
        end
        blk[62] = {7'd0, eff_len[5]};
        blk[63] = {eff_len[4:0], 3'd0};
        for (int t = 0; t < 16; t++) begin
            n_blkw[t] = {blk[4*t], blk[4*t+1], blk[4*t+2], blk[4*t+3]};
        end
    end

    logic               r_vld [NST];
    logic [NONCE_W-1:0] r_nonce [NST];
    t_state             st_v [ROUNDS+1];
    t_sched             st_w [ROUNDS+1];
    t_sched             r_w0;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_w0 <= n_blkw;
            r_nonce[0] <= i_nonce;
            for (int s = 1; s < NST; s++) begin
                r_nonce[s] <= r_nonce[s-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < NST; s++) r_vld[s] <= 1'b0;
        end else if (adv) begin
            r_vld[0] <= i_valid;
            for (int s = 1; s < NST; s++) r_vld[s] <= r_vld[s-1];
        end
    end

    always_comb begin
        for (int j = 0; j < 8; j++) st_v[0][j] = INIT_H[j];
        st_w[0] = r_w0;
    end

    for (genvar g = 0; g < ROUNDS; g++) begin : g_rnd
        shand_round #(.RoundIdx(g)) u_rnd (
            .i_clk (i_clk),
            .i_en  (adv),
            .i_v   (st_v[g]),
            .i_w   (st_w[g]),
            .o_v   (st_v[g+1]),
            .o_w   (st_w[g+1])
        );
    end

    // Final add and difficulty compare.
    t_word      h [8];
    logic [255:0] dig;
    logic [5:0] need;
    logic       n_hit;
    always_comb begin
        for (int j = 0; j < 8; j++) h[j] = st_v[ROUNDS][j] + INIT_H[j];
        dig = {h[0], h[1], h[2], h[3], h[4], h[5], h[6], h[7]};
        need = (r_znib > 6'(DIGEST_NIB)) ? 6'(DIGEST_NIB) : r_znib;
        n_hit = 1'b1;
        for (int n = 0; n < DIGEST_NIB; n++) begin
            if (6'(n) < need && dig[255-4*n -: 4] != 4'h0) n_hit = 1'b0;
        end
    end

    logic         r_hit;
    logic [255:0] r_dig;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_hit <= n_hit;
            r_dig <= dig;
        end
    end

    assign o_valid         = r_vld[NST-1];
    assign o_hit           = r_hit;
    assign o_digest_word_0 = r_dig[255:192];
    assign o_digest_word_1 = r_dig[191:128];
    assign o_digest_word_2 = r_dig[127:64];
    assign o_digest_word_3 = r_dig[63:0];
    assign o_tried_nonce   = r_nonce[NST-1];

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_tried_nonce) && $stable(o_hit)))
        else $error("stalled result changed");
    a_stall_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled without a held result");
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[NST-2] && adv) |=> o_valid)
        else $error("item lost in last stage");
    a_zero_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_znib == 6'd0) |-> n_hit)
        else $error("zero count must hit");

endmodule
